### rtl/core/i2cm_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cm_pkg;

    localparam int HALF_DELAY_W = 10;
    localparam int TIMEOUT_W    = 16;
    localparam int CFG_DATA_W   = 16;

    localparam logic [HALF_DELAY_W-1:0] HALF_DELAY_RST = 10'd2;
    localparam logic [TIMEOUT_W-1:0]    ACK_TIMEOUT_RST = 16'd1000;

    // configuration register indexes
    localparam logic CFG_HALF_DELAY  = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    // command codes
    localparam logic [2:0] MODE_NONE  = 3'd0;
    localparam logic [2:0] MODE_START = 3'd1;
    localparam logic [2:0] MODE_STOP  = 3'd2;
    localparam logic [2:0] MODE_WRITE = 3'd3;
    localparam logic [2:0] MODE_READ  = 3'd4;
    localparam logic [2:0] MODE_WACK  = 3'd5;

    typedef enum logic [22:0] {
        PH_IDLE    = 23'h000001,
        PH_ST_A    = 23'h000002,
        PH_ST_B    = 23'h000004,
        PH_ST_C    = 23'h000008,
        PH_SP_A    = 23'h000010,
        PH_SP_B    = 23'h000020,
        PH_SP_C    = 23'h000040,
        PH_WR_LOW  = 23'h000080,
        PH_WR_DATA = 23'h000100,
        PH_WR_HIGH = 23'h000200,
        PH_WR_END  = 23'h000400,
        PH_RD_LOW  = 23'h000800,
        PH_RD_HIGH = 23'h001000,
        PH_RD_FALL = 23'h002000,
        PH_RA_LOW  = 23'h004000,
        PH_RA_SDA  = 23'h008000,
        PH_RA_HIGH = 23'h010000,
        PH_RA_FALL = 23'h020000,
        PH_RA_REL  = 23'h040000,
        PH_WA_REL  = 23'h080000,
        PH_WA_HIGH = 23'h100000,
        PH_WA_POLL = 23'h200000,
        PH_WA_FALL = 23'h400000
    } phase_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_data;
        logic       ack_result;
    } result_t;

endpackage

### rtl/core/i2cm_if.sv
// Tick and result channel interfaces for the I2C master bit engine.
interface i2cm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] data_byte;
    logic       send_nack;
    logic       sda_in;

    modport source (output valid, output mode, output data_byte, output send_nack,
                    output sda_in, input ready);
    modport sink   (input valid, input mode, input data_byte, input send_nack,
                    input sda_in, output ready);
endinterface

interface i2cm_out_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_result;

    modport source (output valid, output scl_level, output sda_level, output sda_drive,
                    output busy_res, output done_res, output rx_data,
                    output ack_result, input ready);
    modport sink   (input valid, input scl_level, input sda_level, input sda_drive,
                    input busy_res, input done_res, input rx_data,
                    input ack_result, output ready);
endinterface

### rtl/core/i2cm_out_skid.sv
// Result register with one skid entry.
module i2cm_out_skid
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  i2cm_pkg::result_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output i2cm_pkg::result_t  out_data
);

    logic              out_valid_reg;
    logic              skid_valid_reg;
    i2cm_pkg::result_t out_data_reg;
    i2cm_pkg::result_t skid_data_reg;
    logic              in_fire;
    logic              slot_free;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign slot_free = out_ready || !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            out_valid_reg  <= skid_valid_reg || in_fire;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (in_fire)
        begin
            skid_data_reg <= in_data;
        end
    end

    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && out_ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid entry not moved to output register");

    a_no_skid_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !skid_valid_reg && slot_free |=> !skid_valid_reg)
        else $error("skid entry filled while output register was free");

endmodule

### rtl/core/i2c_master_bit_engine.sv
// Top level of the I2C master bit engine: bus phase sequencer and result channel.
//
// Usage:
//   in_ch carries one beat per bus tick: mode (command, only taken while idle),
//   data_byte, send_nack and the sampled sda_in level. Every accepted beat
//   advances the sequencer by exactly one tick.
//   out_ch returns one beat per input beat: pin levels (scl_level, sda_level,
//   sda_drive), busy_res, done_res, rx_data and ack_result, all as they stand
//   after that tick.
//   cfg_we/cfg_index/cfg_wdata write half_delay (index 0) and ack_timeout
//   (index 1); write only while no result is outstanding.
// Result path: the result of a beat is registered into the output register,
//   or into the skid entry while the output register holds a stalled result.
// Throughput: one beat per cycle while ready is high; the sequencer state updates
//   in the same cycle the beat is accepted, so only the receiver limits the rate.
// Stall: a held result plus one skid entry absorb a stalled receiver; in_ch
//   drops ready only while the skid entry is full.
// Reset: bus released (SCL=1, SDA=1, driven), sequencer idle, half_delay=2,
//   ack_timeout=1000, no result pending.
module i2c_master_bit_engine
(
    input  logic                                clk,
    input  logic                                rst_n,
    i2cm_in_if.sink                             in_ch,
    i2cm_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic                                cfg_index,
    input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // configuration
    logic [i2cm_pkg::HALF_DELAY_W-1:0] half_delay_reg;
    logic [i2cm_pkg::TIMEOUT_W-1:0]    ack_timeout_reg;

    // sequencer state
    i2cm_pkg::phase_t                  phase_reg, phase_next;
    logic [3:0]                        bit_count_reg, bit_count_next;
    logic [7:0]                        shift_reg, shift_next;
    logic [i2cm_pkg::HALF_DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic [i2cm_pkg::TIMEOUT_W-1:0]    timeout_count_reg, timeout_count_next;
    logic                              scl_reg, scl_next;
    logic                              sda_reg, sda_next;
    logic                              drive_reg, drive_next;
    logic                              ack_nack_reg, ack_nack_next;
    logic                              nack_req_reg, nack_req_next;
    logic [7:0]                        rx_reg, rx_next;
    logic                              done_next;

    // helpers
    logic                              do_enter;
    i2cm_pkg::phase_t                  enter_ph;
    logic [i2cm_pkg::HALF_DELAY_W-1:0] d_eff;
    logic [3:0]                        bc_inc;
    logic [i2cm_pkg::TIMEOUT_W-1:0]    tmo_dec;
    logic                              in_fire;
    logic                              res_ready;
    i2cm_pkg::result_t                 res;
    i2cm_pkg::result_t                 out_res;

    assign in_fire = in_ch.valid && res_ready;
    assign in_ch.ready = res_ready;

    // zero half_delay behaves as one tick
    assign d_eff   = (half_delay_reg == '0) ? {{(i2cm_pkg::HALF_DELAY_W-1){1'b0}}, 1'b1}
                                            : half_delay_reg;
    assign bc_inc  = bit_count_reg + 4'd1;
    assign tmo_dec = timeout_count_reg - 16'd1;

    always_comb
    begin
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_next         = shift_reg;
        delay_count_next   = delay_count_reg;
        timeout_count_next = timeout_count_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        drive_next         = drive_reg;
        ack_nack_next      = ack_nack_reg;
        nack_req_next      = nack_req_reg;
        rx_next            = rx_reg;
        done_next          = 1'b0;
        do_enter           = 1'b0;
        enter_ph           = i2cm_pkg::PH_IDLE;

        // pick the phase to enter this tick
        if (phase_reg == i2cm_pkg::PH_IDLE)
        begin
            bit_count_next = 4'd0;
            do_enter = 1'b1;
            unique case (in_ch.mode)
                i2cm_pkg::MODE_START: enter_ph = i2cm_pkg::PH_ST_A;
                i2cm_pkg::MODE_STOP:  enter_ph = i2cm_pkg::PH_SP_A;
                i2cm_pkg::MODE_WRITE:
                begin
                    shift_next = in_ch.data_byte;
                    enter_ph   = i2cm_pkg::PH_WR_LOW;
                end
                i2cm_pkg::MODE_READ:
                begin
                    shift_next    = 8'd0;
                    nack_req_next = in_ch.send_nack;
                    enter_ph      = i2cm_pkg::PH_RD_LOW;
                end
                i2cm_pkg::MODE_WACK:
                begin
                    timeout_count_next = ack_timeout_reg;
                    enter_ph           = i2cm_pkg::PH_WA_REL;
                end
                default:
                begin
                    bit_count_next = bit_count_reg;
                    do_enter       = 1'b0;
                end
            endcase
        end
        else if (delay_count_reg > {{(i2cm_pkg::HALF_DELAY_W-1){1'b0}}, 1'b1})
        begin
            delay_count_next = delay_count_reg - {{(i2cm_pkg::HALF_DELAY_W-1){1'b0}}, 1'b1};
        end
        else
        begin
            do_enter = 1'b1;
            unique case (phase_reg)
                i2cm_pkg::PH_ST_A:    enter_ph = i2cm_pkg::PH_ST_B;
                i2cm_pkg::PH_ST_B:    enter_ph = i2cm_pkg::PH_ST_C;
                i2cm_pkg::PH_SP_A:    enter_ph = i2cm_pkg::PH_SP_B;
                i2cm_pkg::PH_SP_B:    enter_ph = i2cm_pkg::PH_SP_C;
                i2cm_pkg::PH_WR_LOW:  enter_ph = i2cm_pkg::PH_WR_DATA;
                i2cm_pkg::PH_WR_DATA: enter_ph = i2cm_pkg::PH_WR_HIGH;
                i2cm_pkg::PH_WR_HIGH:
                begin
                    bit_count_next = bc_inc;
                    enter_ph = (bc_inc >= 4'd8) ? i2cm_pkg::PH_WR_END : i2cm_pkg::PH_WR_LOW;
                end
                i2cm_pkg::PH_RD_LOW:  enter_ph = i2cm_pkg::PH_RD_HIGH;
                i2cm_pkg::PH_RD_HIGH:
                begin
                    // sample SDA as the high phase ends
                    shift_next = {shift_reg[6:0], in_ch.sda_in};
                    enter_ph   = i2cm_pkg::PH_RD_FALL;
                end
                i2cm_pkg::PH_RD_FALL:
                begin
                    bit_count_next = bc_inc;
                    if (bc_inc >= 4'd8)
                    begin
                        rx_next  = shift_reg;
                        enter_ph = i2cm_pkg::PH_RA_LOW;
                    end
                    else
                    begin
                        enter_ph = i2cm_pkg::PH_RD_HIGH;
                    end
                end
                i2cm_pkg::PH_RA_LOW:  enter_ph = i2cm_pkg::PH_RA_SDA;
                i2cm_pkg::PH_RA_SDA:  enter_ph = i2cm_pkg::PH_RA_HIGH;
                i2cm_pkg::PH_RA_HIGH: enter_ph = i2cm_pkg::PH_RA_FALL;
                i2cm_pkg::PH_RA_FALL:
                begin
                    // a NACK ends the read right here
                    if (nack_req_reg)
                    begin
                        do_enter = 1'b0;
                    end
                    enter_ph = i2cm_pkg::PH_RA_REL;
                end
                i2cm_pkg::PH_WA_REL:  enter_ph = i2cm_pkg::PH_WA_HIGH;
                i2cm_pkg::PH_WA_HIGH: enter_ph = i2cm_pkg::PH_WA_POLL;
                i2cm_pkg::PH_WA_POLL:
                begin
                    if (!in_ch.sda_in)
                    begin
                        ack_nack_next = 1'b0;
                        enter_ph      = i2cm_pkg::PH_WA_FALL;
                    end
                    else
                    begin
                        timeout_count_next = tmo_dec;
                        if (tmo_dec == '0)
                        begin
                            // timed out: send stop, report NACK
                            ack_nack_next = 1'b1;
                            enter_ph      = i2cm_pkg::PH_SP_A;
                        end
                        else
                        begin
                            enter_ph = i2cm_pkg::PH_WA_POLL;
                        end
                    end
                end
                default:
                begin
                    // last phase of a command
                    do_enter = 1'b0;
                end
            endcase

            if (!do_enter)
            begin
                phase_next       = i2cm_pkg::PH_IDLE;
                delay_count_next = '0;
                done_next        = 1'b1;
            end
        end

        // pin levels set on phase entry
        if (do_enter)
        begin
            phase_next       = enter_ph;
            delay_count_next = d_eff;
            unique case (enter_ph)
                i2cm_pkg::PH_ST_A:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b1;
                    scl_next   = 1'b1;
                end
                i2cm_pkg::PH_ST_B: sda_next = 1'b0;
                i2cm_pkg::PH_ST_C:
                begin
                    scl_next         = 1'b0;
                    delay_count_next = {{(i2cm_pkg::HALF_DELAY_W-1){1'b0}}, 1'b1};
                end
                i2cm_pkg::PH_SP_A:
                begin
                    drive_next = 1'b1;
                    sda_next   = 1'b0;
                    scl_next   = 1'b0;
                end
                i2cm_pkg::PH_SP_B: scl_next = 1'b1;
                i2cm_pkg::PH_SP_C: sda_next = 1'b1;
                i2cm_pkg::PH_WR_LOW:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                end
                i2cm_pkg::PH_WR_DATA:
                begin
                    sda_next   = shift_next[7];
                    shift_next = {shift_next[6:0], 1'b0};
                end
                i2cm_pkg::PH_WR_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_WR_END:  scl_next = 1'b0;
                i2cm_pkg::PH_RD_LOW:  scl_next = 1'b0;
                i2cm_pkg::PH_RD_HIGH:
                begin
                    sda_next   = 1'b1;
                    drive_next = 1'b0;
                    scl_next   = 1'b1;
                end
                i2cm_pkg::PH_RD_FALL: scl_next = 1'b0;
                i2cm_pkg::PH_RA_LOW:
                begin
                    drive_next = 1'b1;
                    scl_next   = 1'b0;
                end
                i2cm_pkg::PH_RA_SDA:  sda_next = nack_req_next;
                i2cm_pkg::PH_RA_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_RA_FALL: scl_next = 1'b0;
                i2cm_pkg::PH_RA_REL:
                begin
                    sda_next         = 1'b1;
                    delay_count_next = {{(i2cm_pkg::HALF_DELAY_W-1){1'b0}}, 1'b1};
                end
                i2cm_pkg::PH_WA_REL:
                begin
                    drive_next = 1'b0;
                    sda_next   = 1'b1;
                end
                i2cm_pkg::PH_WA_HIGH: scl_next = 1'b1;
                i2cm_pkg::PH_WA_POLL:
                begin
                    delay_count_next = {{(i2cm_pkg::HALF_DELAY_W-1){1'b0}}, 1'b1};
                end
                i2cm_pkg::PH_WA_FALL: scl_next = 1'b0;
                default:
                begin
                end
            endcase
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_delay_reg  <= i2cm_pkg::HALF_DELAY_RST;
            ack_timeout_reg <= i2cm_pkg::ACK_TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                i2cm_pkg::CFG_HALF_DELAY:
                    half_delay_reg <= cfg_wdata[i2cm_pkg::HALF_DELAY_W-1:0];
                i2cm_pkg::CFG_ACK_TIMEOUT:
                    ack_timeout_reg <= cfg_wdata[i2cm_pkg::TIMEOUT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer advances one tick per accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= i2cm_pkg::PH_IDLE;
            bit_count_reg     <= 4'd0;
            shift_reg         <= 8'd0;
            delay_count_reg   <= '0;
            timeout_count_reg <= '0;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
            drive_reg         <= 1'b1;
            ack_nack_reg      <= 1'b0;
            nack_req_reg      <= 1'b0;
            rx_reg            <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            bit_count_reg     <= bit_count_next;
            shift_reg         <= shift_next;
            delay_count_reg   <= delay_count_next;
            timeout_count_reg <= timeout_count_next;
            scl_reg           <= scl_next;
            sda_reg           <= sda_next;
            drive_reg         <= drive_next;
            ack_nack_reg      <= ack_nack_next;
            nack_req_reg      <= nack_req_next;
            rx_reg            <= rx_next;
        end
    end

    assign res.scl_level  = scl_next;
    assign res.sda_level  = sda_next;
    assign res.sda_drive  = drive_next;
    assign res.busy_res   = (phase_next != i2cm_pkg::PH_IDLE);
    assign res.done_res   = done_next;
    assign res.rx_data    = rx_next;
    assign res.ack_result = ack_nack_next;

    i2cm_out_skid u_out_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_res)
    );

    assign out_ch.scl_level  = out_res.scl_level;
    assign out_ch.sda_level  = out_res.sda_level;
    assign out_ch.sda_drive  = out_res.sda_drive;
    assign out_ch.busy_res   = out_res.busy_res;
    assign out_ch.done_res   = out_res.done_res;
    assign out_ch.rx_data    = out_res.rx_data;
    assign out_ch.ack_result = out_res.ack_result;

    a_idle_no_delay: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == i2cm_pkg::PH_IDLE) == (delay_count_reg == '0))
        else $error("delay counter out of step with idle phase");

    a_release_high: assert property (@(posedge clk) disable iff (!rst_n)
        !drive_reg |-> sda_reg)
        else $error("SDA released with output latch low");

    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && done_next |=> phase_reg == i2cm_pkg::PH_IDLE)
        else $error("done pulsed without returning to idle");

    a_hold_without_beat: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(phase_reg) && $stable(delay_count_reg))
        else $error("sequencer moved without an accepted beat");

endmodule

### tb/tb_i2c_master_bit_engine.sv
// Self-checking testbench for the I2C master bit engine: tick stream in, pin/status beats out.
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine;

    // unused command codes, must be ignored by the sequencer
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    // cycles with no beat on either channel before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // marks an ACK wait whose SDA never drops (forces the timeout path)
    localparam int SDA_STUCK_HIGH = 32'h3fff_ffff;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] data_byte;
        logic       send_nack;
        logic       sda_in;
    } tick_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    i2cm_in_if  in_ch();
    i2cm_out_if out_ch();

    i2c_master_bit_engine dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ticks waiting to be sent, and pin/status beats the engine owes us
    tick_t             tick_q[$];
    i2cm_pkg::result_t pin_expect_q[$];

    // per-cycle idle chance (percent) of the tick sender and the result receiver
    int src_gap_pct;
    int snk_gap_pct;
    int err_count;
    int res_beats;
    int stall_cycles;

    // ------------------------------------------------------------------
    // Bus sequencer mirror: timing registers plus the engine's own state
    // ------------------------------------------------------------------
    logic [9:0]       hd_cfg;
    logic [15:0]      to_cfg;
    i2cm_pkg::phase_t ph;
    logic [3:0]       bit_cnt;
    logic [7:0]       shreg;
    logic [7:0]       rx_r;
    logic [9:0]       dly;
    logic [15:0]      to_cnt;
    logic             scl_r;
    logic             sda_r;
    logic             drv_r;
    logic             nack_r;
    logic             ack_flag;
    logic             done_r;

    task automatic bus_reset();
        hd_cfg   = i2cm_pkg::HALF_DELAY_RST;
        to_cfg   = i2cm_pkg::ACK_TIMEOUT_RST;
        ph       = i2cm_pkg::PH_IDLE;
        bit_cnt  = '0;
        shreg    = '0;
        rx_r     = '0;
        dly      = '0;
        to_cnt   = '0;
        scl_r    = 1'b1;   // bus released, pins driven high
        sda_r    = 1'b1;
        drv_r    = 1'b1;
        nack_r   = 1'b0;
        ack_flag = 1'b0;
        done_r   = 1'b0;
    endtask

    // Pin levels are set when a phase begins; the phase then holds for
    // half_delay ticks (zero is taken as one) unless it is a one-tick phase.
    task automatic bus_enter(input i2cm_pkg::phase_t p);
        ph  = p;
        dly = (hd_cfg == 10'd0) ? 10'd1 : hd_cfg;
        case (p)
            i2cm_pkg::PH_ST_A:    begin drv_r = 1'b1; sda_r = 1'b1; scl_r = 1'b1; end
            i2cm_pkg::PH_ST_B:    sda_r = 1'b0;
            i2cm_pkg::PH_ST_C:    begin scl_r = 1'b0; dly = 10'd1; end
            i2cm_pkg::PH_SP_A:    begin drv_r = 1'b1; sda_r = 1'b0; scl_r = 1'b0; end
            i2cm_pkg::PH_SP_B:    scl_r = 1'b1;
            i2cm_pkg::PH_SP_C:    sda_r = 1'b1;
            i2cm_pkg::PH_WR_LOW:  begin drv_r = 1'b1; scl_r = 1'b0; end
            i2cm_pkg::PH_WR_DATA:
            begin
                sda_r = shreg[7];
                shreg = {shreg[6:0], 1'b0};
            end
            i2cm_pkg::PH_WR_HIGH: scl_r = 1'b1;
            i2cm_pkg::PH_WR_END:  scl_r = 1'b0;
            i2cm_pkg::PH_RD_LOW:  scl_r = 1'b0;
            i2cm_pkg::PH_RD_HIGH: begin sda_r = 1'b1; drv_r = 1'b0; scl_r = 1'b1; end
            i2cm_pkg::PH_RD_FALL: scl_r = 1'b0;
            i2cm_pkg::PH_RA_LOW:  begin drv_r = 1'b1; scl_r = 1'b0; end
            i2cm_pkg::PH_RA_SDA:  sda_r = nack_r;
            i2cm_pkg::PH_RA_HIGH: scl_r = 1'b1;
            i2cm_pkg::PH_RA_FALL: scl_r = 1'b0;
            i2cm_pkg::PH_RA_REL:  begin sda_r = 1'b1; dly = 10'd1; end
            i2cm_pkg::PH_WA_REL:  begin drv_r = 1'b0; sda_r = 1'b1; end
            i2cm_pkg::PH_WA_HIGH: scl_r = 1'b1;
            i2cm_pkg::PH_WA_POLL: dly = 10'd1;
            i2cm_pkg::PH_WA_FALL: scl_r = 1'b0;
            default:              begin ph = i2cm_pkg::PH_IDLE; dly = '0; end
        endcase
    endtask

    task automatic bus_go_idle();
        ph     = i2cm_pkg::PH_IDLE;
        dly    = '0;
        done_r = 1'b1;
    endtask

    // What happens when the hold time of the current phase runs out.
    task automatic bus_phase_end(input logic sda);
        case (ph)
            i2cm_pkg::PH_ST_A:    bus_enter(i2cm_pkg::PH_ST_B);
            i2cm_pkg::PH_ST_B:    bus_enter(i2cm_pkg::PH_ST_C);
            i2cm_pkg::PH_SP_A:    bus_enter(i2cm_pkg::PH_SP_B);
            i2cm_pkg::PH_SP_B:    bus_enter(i2cm_pkg::PH_SP_C);
            i2cm_pkg::PH_WR_LOW:  bus_enter(i2cm_pkg::PH_WR_DATA);
            i2cm_pkg::PH_WR_DATA: bus_enter(i2cm_pkg::PH_WR_HIGH);
            i2cm_pkg::PH_WR_HIGH:
            begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8)
                    bus_enter(i2cm_pkg::PH_WR_END);
                else
                    bus_enter(i2cm_pkg::PH_WR_LOW);
            end
            i2cm_pkg::PH_RD_LOW:  bus_enter(i2cm_pkg::PH_RD_HIGH);
            i2cm_pkg::PH_RD_HIGH:
            begin
                // SDA is sampled as the SCL-high phase ends
                shreg = {shreg[6:0], sda};
                bus_enter(i2cm_pkg::PH_RD_FALL);
            end
            i2cm_pkg::PH_RD_FALL:
            begin
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= 4'd8)
                begin
                    rx_r = shreg;
                    bus_enter(i2cm_pkg::PH_RA_LOW);
                end
                else
                    bus_enter(i2cm_pkg::PH_RD_HIGH);
            end
            i2cm_pkg::PH_RA_LOW:  bus_enter(i2cm_pkg::PH_RA_SDA);
            i2cm_pkg::PH_RA_SDA:  bus_enter(i2cm_pkg::PH_RA_HIGH);
            i2cm_pkg::PH_RA_HIGH: bus_enter(i2cm_pkg::PH_RA_FALL);
            i2cm_pkg::PH_RA_FALL:
            begin
                // after an ACK the master parks SDA high for one more tick
                if (nack_r)
                    bus_go_idle();
                else
                    bus_enter(i2cm_pkg::PH_RA_REL);
            end
            i2cm_pkg::PH_WA_REL:  bus_enter(i2cm_pkg::PH_WA_HIGH);
            i2cm_pkg::PH_WA_HIGH: bus_enter(i2cm_pkg::PH_WA_POLL);
            i2cm_pkg::PH_WA_POLL:
            begin
                if (!sda)
                begin
                    ack_flag = 1'b0;
                    bus_enter(i2cm_pkg::PH_WA_FALL);
                end
                else
                begin
                    // 16-bit down counter: a zero timeout wraps to 65536 polls
                    to_cnt = to_cnt - 16'd1;
                    if (to_cnt == 16'd0)
                    begin
                        ack_flag = 1'b1;
                        bus_enter(i2cm_pkg::PH_SP_A);
                    end
                    else
                        bus_enter(i2cm_pkg::PH_WA_POLL);
                end
            end
            default:    bus_go_idle();
        endcase
    endtask

    // One accepted tick: commands are taken only while idle, otherwise the
    // running phase counts down or ends. Returns the pins as they stand after.
    task automatic bus_tick(input logic [2:0] m, input logic [7:0] b, input logic nk,
                            input logic sda, output i2cm_pkg::result_t r);
        done_r = 1'b0;
        if (ph == i2cm_pkg::PH_IDLE)
        begin
            if (m >= i2cm_pkg::MODE_START && m <= i2cm_pkg::MODE_WACK)
            begin
                bit_cnt = '0;
                case (m)
                    i2cm_pkg::MODE_START: bus_enter(i2cm_pkg::PH_ST_A);
                    i2cm_pkg::MODE_STOP:  bus_enter(i2cm_pkg::PH_SP_A);
                    i2cm_pkg::MODE_WRITE:
                    begin
                        shreg = b;
                        bus_enter(i2cm_pkg::PH_WR_LOW);
                    end
                    i2cm_pkg::MODE_READ:
                    begin
                        shreg  = '0;
                        nack_r = nk;
                        bus_enter(i2cm_pkg::PH_RD_LOW);
                    end
                    default:
                    begin
                        to_cnt = to_cfg;
                        bus_enter(i2cm_pkg::PH_WA_REL);
                    end
                endcase
            end
        end
        else if (dly > 10'd1)
            dly = dly - 10'd1;
        else
            bus_phase_end(sda);

        r.scl_level  = scl_r;
        r.sda_level  = sda_r;
        r.sda_drive  = drv_r;
        r.busy_res   = (ph != i2cm_pkg::PH_IDLE);
        r.done_res   = done_r;
        r.rx_data    = rx_r;
        r.ack_result = ack_flag;
    endtask

    // ------------------------------------------------------------------
    // Error reporting
    // ------------------------------------------------------------------
    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        // every block input is known from time zero
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = i2cm_pkg::CFG_HALF_DELAY;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.mode         = i2cm_pkg::MODE_NONE;
        in_ch.data_byte    = '0;
        in_ch.send_nack    = 1'b0;
        in_ch.sda_in       = 1'b1;
        out_ch.ready       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Tick driver: on each accepted beat the mirror advances one tick and
    // the resulting pin/status beat is queued. A new beat is offered only
    // once the previous one is gone, so valid never drops mid-handshake.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : tick_driver
        i2cm_pkg::result_t want;
        tick_t             nxt;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                bus_tick(in_ch.mode, in_ch.data_byte, in_ch.send_nack, in_ch.sda_in, want);
                pin_expect_q.push_back(want);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (tick_q.size() != 0 && $urandom_range(0, 99) >= src_gap_pct)
                begin
                    nxt = tick_q.pop_front();
                    in_ch.mode      <= nxt.mode;
                    in_ch.data_byte <= nxt.data_byte;
                    in_ch.send_nack <= nxt.send_nack;
                    in_ch.sda_in    <= nxt.sda_in;
                    in_ch.valid     <= 1'b1;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: random back-pressure, each beat checked in order
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : pin_monitor
        i2cm_pkg::result_t got;
        i2cm_pkg::result_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.scl_level  = out_ch.scl_level;
                got.sda_level  = out_ch.sda_level;
                got.sda_drive  = out_ch.sda_drive;
                got.busy_res   = out_ch.busy_res;
                got.done_res   = out_ch.done_res;
                got.rx_data    = out_ch.rx_data;
                got.ack_result = out_ch.ack_result;
                if (pin_expect_q.size() == 0)
                    flag_error($sformatf("beat %0d arrived with nothing expected", res_beats));
                else
                begin
                    // fields packed scl, sda, drive, busy, done, rx_data, ack
                    want = pin_expect_q.pop_front();
                    if (got !== want)
                        flag_error($sformatf("beat %0d: got %h, want %h",
                                             res_beats, got, want));
                end
                res_beats++;
            end
            out_ch.ready <= ($urandom_range(0, 99) >= snk_gap_pct);
        end
    end

    // Watchdog: a long run of cycles with no beat on either side means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Wait until every tick is sent and every beat checked, then give the
    // output register some margin.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (tick_q.size() != 0 || in_ch.valid || pin_expect_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Timing registers are only touched with the sequencer idle: feed plain
    // ticks (SDA high) until any command still running has finished.
    task automatic settle_idle();
        tick_t t;
        wait_drained();
        while (ph != i2cm_pkg::PH_IDLE)
        begin
            repeat (16)
            begin
                t.mode      = i2cm_pkg::MODE_NONE;
                t.data_byte = 8'($urandom_range(0, 255));
                t.send_nack = 1'($urandom_range(0, 1));
                t.sda_in    = 1'b1;
                tick_q.push_back(t);
            end
            wait_drained();
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == i2cm_pkg::CFG_HALF_DELAY)
            hd_cfg = value[9:0];
        else
            to_cfg = value;
    endtask

    task automatic set_timing(input logic [9:0] d, input logic [15:0] t);
        settle_idle();
        write_reg(i2cm_pkg::CFG_HALF_DELAY, {6'd0, d});
        write_reg(i2cm_pkg::CFG_ACK_TIMEOUT, t);
    endtask

    // Queue one command tick plus the busy ticks it should occupy. Busy ticks
    // carry random modes (the engine must ignore them). SDA on the busy ticks
    // is held high for hi_ticks, then follows sda_sel (-1 random, else fixed).
    // ragged cuts the busy stretch short so the next command hits a busy engine.
    task automatic queue_command(input logic [2:0] m, input logic [7:0] b, input logic nk,
                                 input int sda_sel, input int hi_ticks, input bit ragged);
        tick_t t;
        int    d;
        int    polls;
        int    span;
        int    first_low;
        d     = (hd_cfg == 10'd0) ? 1 : int'(hd_cfg);
        polls = (to_cfg == 16'd0) ? 65536 : int'(to_cfg);
        case (m)
            i2cm_pkg::MODE_START: span = 2 * d + 1;
            i2cm_pkg::MODE_STOP:  span = 3 * d;
            i2cm_pkg::MODE_WRITE: span = 25 * d;
            i2cm_pkg::MODE_READ:  span = nk ? 21 * d : 21 * d + 1;
            i2cm_pkg::MODE_WACK:
            begin
                // polling starts 2D+1 ticks after the command
                first_low = (hi_ticks + 1 > 2 * d + 1) ? hi_ticks + 1 : 2 * d + 1;
                if (first_low <= 2 * d + polls)
                    span = first_low + d;
                else
                    span = 5 * d + polls;  // timeout, then a stop sequence
            end
            default:    span = 0;
        endcase
        if (ragged)
            span = int'($urandom_range(0, span));

        t.mode      = m;
        t.data_byte = b;
        t.send_nack = nk;
        t.sda_in    = 1'($urandom_range(0, 1));
        tick_q.push_back(t);
        for (int i = 0; i < span; i++)
        begin
            t.mode      = 3'($urandom_range(0, 7));
            t.data_byte = 8'($urandom_range(0, 255));
            t.send_nack = 1'($urandom_range(0, 1));
            if (i < hi_ticks)
                t.sda_in = 1'b1;
            else if (sda_sel < 0)
                t.sda_in = 1'($urandom_range(0, 1));
            else
                t.sda_in = sda_sel[0];
            tick_q.push_back(t);
        end
        // short idle gap with do-nothing modes
        repeat ($urandom_range(0, 2))
        begin
            case ($urandom_range(0, 2))
                0:       t.mode = i2cm_pkg::MODE_NONE;
                1:       t.mode = MODE_SPARE6;
                default: t.mode = MODE_SPARE7;
            endcase
            t.data_byte = 8'($urandom_range(0, 255));
            t.send_nack = 1'($urandom_range(0, 1));
            t.sda_in    = 1'($urandom_range(0, 1));
            tick_q.push_back(t);
        end
    endtask

    // Random command mix; timing is re-rolled every 75 commands.
    task automatic run_random(input int n);
        logic [2:0] m;
        int         d;
        int         polls;
        int         sel;
        int         hi;
        for (int k = 0; k < n; k++)
        begin
            if (k != 0 && k % 75 == 0)
            begin
                if ($urandom_range(0, 3) == 0)
                    set_timing(10'($urandom_range(7, 40)), 16'($urandom_range(51, 300)));
                else
                    set_timing(10'($urandom_range(1, 6)), 16'($urandom_range(1, 50)));
            end
            d     = (hd_cfg == 10'd0) ? 1 : int'(hd_cfg);
            polls = (to_cfg == 16'd0) ? 65536 : int'(to_cfg);
            if ($urandom_range(0, 19) == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       m = i2cm_pkg::MODE_NONE;
                    1:       m = MODE_SPARE6;
                    default: m = MODE_SPARE7;
                endcase
            end
            else
                m = 3'($urandom_range(i2cm_pkg::MODE_START, i2cm_pkg::MODE_WACK));
            sel = -1;
            hi  = 0;
            if (m == i2cm_pkg::MODE_WACK)
            begin
                sel = 0;
                if ($urandom_range(0, 3) == 0)
                    hi = SDA_STUCK_HIGH;
                else
                    hi = int'($urandom_range(0, 2 * d + polls + 3));
            end
            else if (m == i2cm_pkg::MODE_READ && $urandom_range(0, 3) == 0)
                sel = int'($urandom_range(0, 1));
            queue_command(m, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), sel, hi,
                          $urandom_range(0, 9) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        err_count    = 0;
        res_beats    = 0;
        stall_cycles = 0;
        src_gap_pct  = 19;
        snk_gap_pct  = 52;
        bus_reset();
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Directed pass at reset timing (half_delay 2, ack_timeout 1000)
        queue_command(i2cm_pkg::MODE_START, 8'h00, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WRITE, 8'ha5, 1'b1, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WRITE, 8'h5a, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_READ,  8'h00, 1'b0, -1, 0, 1'b0);  // random bits, ACK
        queue_command(i2cm_pkg::MODE_READ,  8'h00, 1'b1,  1, 0, 1'b0);  // all ones, NACK
        queue_command(i2cm_pkg::MODE_WACK,  8'h00, 1'b0,  0, 0, 1'b0);  // slave ACKs at once
        queue_command(i2cm_pkg::MODE_WACK,  8'h00, 1'b0,  0, 8, 1'b0);  // late ACK
        queue_command(i2cm_pkg::MODE_STOP,  8'h00, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_NONE,  8'hff, 1'b1, -1, 0, 1'b0);
        queue_command(MODE_SPARE6, 8'h00, 1'b0, -1, 0, 1'b0);
        queue_command(MODE_SPARE7, 8'hff, 1'b1, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WRITE, 8'hc3, 1'b0, -1, 0, 1'b1);  // next one lands busy
        queue_command(i2cm_pkg::MODE_READ,  8'h00, 1'b0,  0, 0, 1'b0);  // all zeros, ACK

        // Fastest timing, one-poll ACK timeout
        set_timing(10'd1, 16'd1);
        queue_command(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, 0, SDA_STUCK_HIGH, 1'b0);  // timeout
        queue_command(i2cm_pkg::MODE_WACK, 8'h00, 1'b0, 0, 0, 1'b0);  // ACK clears the NACK
        run_random(25);

        // Idling swapped; zero half_delay acts as one, zero timeout wraps
        settle_idle();
        src_gap_pct = 52;
        snk_gap_pct = 19;
        set_timing(10'd0, 16'd0);
        queue_command(i2cm_pkg::MODE_START, 8'h00, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WRITE, 8'h3c, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_READ,  8'h00, 1'b1, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WACK,  8'h00, 1'b0,  0, 5, 1'b0);
        queue_command(i2cm_pkg::MODE_STOP,  8'h00, 1'b0, -1, 0, 1'b0);
        set_timing(10'd3, 16'd12);
        run_random(10);

        // No idling; slower timing and the largest nonzero timeout
        settle_idle();
        src_gap_pct = 0;
        snk_gap_pct = 0;
        set_timing(10'd4, 16'd65535);
        queue_command(i2cm_pkg::MODE_START, 8'h00, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WRITE, 8'($urandom_range(0, 255)), 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_READ,  8'h00, 1'b0, -1, 0, 1'b0);
        queue_command(i2cm_pkg::MODE_WACK,  8'h00, 1'b0,  0, 2 * 4 + 10, 1'b0);
        queue_command(i2cm_pkg::MODE_STOP,  8'h00, 1'b0, -1, 0, 1'b0);
        set_timing(10'd2, 16'd7);
        run_random(8);

        // drain, then some margin for the output register
        wait_drained();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
